[rtl/core/ked_pkg.sv]
// Shared types, constants and lookup functions for the key event decoder.
// Used by ked_arrow and key_event_decoder_autorepeat; depends on nothing.
`default_nettype none

package ked_pkg;

  // Width of arrow hold ages and repeat times
  localparam int TIME_WIDTH = 13;
  // Width of the configuration registers
  localparam int CFG_WIDTH  = 13;
  // Working width for sums and compares of times and register values
  localparam int SUM_W = ((TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH) + 1;

  localparam int KEY_WIDTH = 7;
  localparam int NUM_KEYS  = 68;
  localparam int NUM_ARROWS = 4;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [CFG_WIDTH-1:0]  cfg_val_t;
  typedef logic [KEY_WIDTH-1:0]  key_t;
  typedef logic [6:0]            ascii_t;

  localparam time_t TIME_MAX = {TIME_WIDTH{1'b1}};

  // Item commands
  typedef enum logic [1:0] {
    CMD_KEY       = 2'd0,
    CMD_TICK      = 2'd1,
    CMD_OVERFLOW  = 2'd2,
    CMD_RECONNECT = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_REPEAT_START  = 2'd0;
  localparam logic [1:0] CFG_REPEAT_PERIOD = 2'd1;
  localparam logic [1:0] CFG_HOLD_MAX      = 2'd2;

  localparam cfg_val_t RST_REPEAT_START  = CFG_WIDTH'(350);
  localparam cfg_val_t RST_REPEAT_PERIOD = CFG_WIDTH'(150);
  localparam cfg_val_t RST_HOLD_MAX      = CFG_WIDTH'(5000);

  // Matrix event numbers of the special keys
  localparam key_t K_ESC_A   = 7'd11;
  localparam key_t K_ESC_B   = 7'd12;
  localparam key_t K_CAPS    = 7'd31;
  localparam key_t K_ALT     = 7'd41;
  localparam key_t K_CTRL    = 7'd49;
  localparam key_t K_UP      = 7'd50;
  localparam key_t K_FN_A    = 7'd51;
  localparam key_t K_SHIFT   = 7'd53;
  localparam key_t K_FN_B    = 7'd58;
  localparam key_t K_LEFT    = 7'd59;
  localparam key_t K_DOWN    = 7'd60;
  localparam key_t K_DEL     = 7'd63;
  localparam key_t K_ENTER_A = 7'd64;
  localparam key_t K_ENTER_B = 7'd66;
  localparam key_t K_RIGHT   = 7'd68;

  // Arrow slots in order right, left, up, down
  localparam key_t ARROW_KEY [NUM_ARROWS] = '{K_RIGHT, K_LEFT, K_UP, K_DOWN};

  // ASCII landmarks
  localparam ascii_t CH_LOWER_A = 7'h61;
  localparam ascii_t CH_LOWER_Z = 7'h7A;
  localparam ascii_t CH_DIGIT_0 = 7'h30;
  localparam ascii_t CH_DIGIT_9 = 7'h39;
  localparam ascii_t CASE_DELTA = 7'h20;

  // Repeat timing registers
  typedef struct packed {
    cfg_val_t start;
    cfg_val_t period;
    cfg_val_t hold_max;
  } cfg_t;

  // Per-arrow control for one processed item
  typedef struct packed {
    logic en;       // an item is processed this cycle
    logic tick;     // millisecond tick
    logic clear;    // overflow or reconnect
    logic press;    // this arrow pressed
    logic lift;     // this arrow released
  } arrow_ctl_t;

  // Saturate a working-width value to the time range
  function automatic time_t sat_time(input logic [SUM_W-1:0] v);
    time_t r;
    if (v > SUM_W'(TIME_MAX)) r = TIME_MAX;
    else r = v[TIME_WIDTH-1:0];
    return r;
  endfunction

  // Printable character of a key number, zero for none
  function automatic ascii_t key_char(input key_t key);
    ascii_t c;
    unique case (key)
      7'd13: c = 7'h31;
      7'd14: c = 7'h32;
      7'd15: c = 7'h33;
      7'd16: c = 7'h34;
      7'd17: c = 7'h35;
      7'd18: c = 7'h36;
      7'd19: c = 7'h37;
      7'd20: c = 7'h38;
      7'd21: c = 7'h71;
      7'd22: c = 7'h77;
      7'd23: c = 7'h65;
      7'd24: c = 7'h72;
      7'd25: c = 7'h74;
      7'd26: c = 7'h79;
      7'd27: c = 7'h75;
      7'd28: c = 7'h69;
      7'd29: c = 7'h6F;
      7'd30: c = 7'h70;
      7'd32: c = 7'h61;
      7'd33: c = 7'h73;
      7'd34: c = 7'h64;
      7'd35: c = 7'h66;
      7'd36: c = 7'h67;
      7'd37: c = 7'h68;
      7'd38: c = 7'h6A;
      7'd39: c = 7'h6B;
      7'd40: c = 7'h6C;
      7'd42: c = 7'h7A;
      7'd43: c = 7'h78;
      7'd44: c = 7'h63;
      7'd45: c = 7'h76;
      7'd46: c = 7'h62;
      7'd47: c = 7'h6E;
      7'd48: c = 7'h6D;
      7'd55: c = 7'h20;
      7'd56: c = 7'h20;
      7'd57: c = 7'h20;
      7'd62: c = 7'h39;
      7'd67: c = 7'h30;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Shifted symbol of a decimal digit
  function automatic ascii_t digit_sym(input logic [3:0] d);
    ascii_t c;
    unique case (d)
      4'd0: c = 7'h29;
      4'd1: c = 7'h21;
      4'd2: c = 7'h40;
      4'd3: c = 7'h23;
      4'd4: c = 7'h24;
      4'd5: c = 7'h25;
      4'd6: c = 7'h5E;
      4'd7: c = 7'h26;
      4'd8: c = 7'h2A;
      4'd9: c = 7'h28;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ked_arrow.sv]
// Hold, age and auto-repeat tracking for one arrow key.
// Depends on ked_pkg for time types, config struct and control struct.
`default_nettype none

module ked_arrow
  import ked_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire arrow_ctl_t ctl,
  input  wire cfg_t       cfg,
  output logic            pulse
);

  logic  held_r, held_nxt;
  time_t age_r, age_nxt;
  time_t next_r, next_nxt;

  logic  held_a;
  time_t age_a;
  time_t next_a;
  logic  rep;

  // Apply tick, item action, hold timeout and repeat in model order
  always_comb begin
    held_a = held_r;
    age_a  = age_r;
    next_a = next_r;
    if (ctl.tick && held_r) begin
      age_a = sat_time(SUM_W'(age_r) + SUM_W'(1));
    end
    priority if (ctl.clear) begin
      held_a = 1'b0;
    end else if (ctl.press) begin
      held_a = 1'b1;
      age_a  = '0;
      next_a = sat_time(SUM_W'(cfg.start));
    end else if (ctl.lift) begin
      held_a = 1'b0;
    end else begin
      // no action on this arrow: keep the hold state
    end

    // Drop an arrow held too long
    held_nxt = held_a && !(SUM_W'(age_a) > SUM_W'(cfg.hold_max));
    age_nxt  = age_a;

    // Fire a repeat once the age reaches the scheduled time
    rep      = held_nxt && (age_a >= next_a);
    next_nxt = rep ? sat_time(SUM_W'(age_a) + SUM_W'(cfg.period)) : next_a;
    pulse    = ctl.press || rep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      age_r  <= '0;
      next_r <= '0;
    end else if (ctl.en) begin
      held_r <= held_nxt;
      age_r  <= age_nxt;
      next_r <= next_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/key_event_decoder_autorepeat.sv]
// Top level of the key event decoder with arrow auto-repeat.
// Depends on ked_pkg and instantiates ked_arrow for each arrow key.
//
// One result transaction comes out for every input transaction, in order.
// The block accepts one item per clock while the result side does not stall. An
// item is held in the input register and is written to the result register, which
// presents its result, once the result slot is free. The rate rests on the update
// of the modifier and arrow state registers, which every item reads and writes.
// Stalls on the result side back up through the input register without
// losing items.
// Configuration writes (cfg_ready is always high) take effect for the next
// item processed and are meant to be done while no item is in flight.
`default_nettype none

module key_event_decoder_autorepeat
  import ked_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  // input channel
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [1:0]     in_cmd,
  input  wire logic [6:0]     in_key_number,
  input  wire logic           in_key_pressed,
  // result channel
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                out_char_valid,
  output logic [6:0]          out_char_code,
  output logic                out_next_pulse,
  output logic                out_prev_pulse,
  output logic                out_up_pulse,
  output logic                out_down_pulse,
  output logic                out_select_pulse,
  output logic                out_escape_pulse,
  output logic                out_delete_pulse,
  output logic                out_fn_held,
  output logic                out_ctrl_held,
  output logic                out_alt_held,
  // configuration channel
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [12:0]    cfg_data
);

  typedef struct packed {
    logic                  char_valid;
    ascii_t                char_code;
    logic [NUM_ARROWS-1:0] arrow_pulse;
    logic                  select_pulse;
    logic                  escape_pulse;
    logic                  delete_pulse;
    logic                  fn_held;
    logic                  ctrl_held;
    logic                  alt_held;
  } result_t;

  // Handshake and pipeline registers
  logic    in_vld_r, in_vld_nxt;
  cmd_t    cmd_r;
  key_t    key_r;
  logic    press_r;
  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;
  logic    in_take, out_free, adv;

  // Configuration and modifier state
  cfg_t cfg_r;
  logic shift_r, shift_nxt;
  logic caps_r, caps_nxt;
  logic fn_r, fn_nxt;
  logic ctrl_r, ctrl_nxt;
  logic alt_r, alt_nxt;

  arrow_ctl_t            arrow_ctl [NUM_ARROWS];
  logic [NUM_ARROWS-1:0] arrow_pulse;

  logic   key_ok, is_arrow;
  logic   sel, esc, del, cvalid;
  ascii_t raw_char, ccode;

  // Flow control: the input register moves on whenever the result slot frees
  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = in_vld_r && out_free;
  assign in_stall  = in_vld_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) in_vld_nxt = 1'b1;
    else if (adv) in_vld_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = 1'b1;
    else if (out_free) out_valid_nxt = 1'b0;
  end

  // Decode the item and update modifiers
  assign key_ok   = (key_r >= KEY_WIDTH'(1)) && (key_r <= KEY_WIDTH'(NUM_KEYS));
  assign is_arrow = (key_r == K_RIGHT) || (key_r == K_LEFT) ||
                    (key_r == K_UP) || (key_r == K_DOWN);
  assign raw_char = key_char(key_r);

  always_comb begin
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    fn_nxt    = fn_r;
    ctrl_nxt  = ctrl_r;
    alt_nxt   = alt_r;
    sel       = 1'b0;
    esc       = 1'b0;
    del       = 1'b0;
    cvalid    = 1'b0;
    ccode     = '0;
    unique case (cmd_r)
      CMD_RECONNECT: begin
        shift_nxt = 1'b0;
        caps_nxt  = 1'b0;
        fn_nxt    = 1'b0;
        ctrl_nxt  = 1'b0;
        alt_nxt   = 1'b0;
      end
      CMD_KEY: begin
        if (key_ok) begin
          priority if (key_r == K_SHIFT) begin
            shift_nxt = press_r;
          end else if (key_r == K_CTRL) begin
            ctrl_nxt = press_r;
          end else if (key_r == K_ALT) begin
            alt_nxt = press_r;
          end else if (key_r == K_FN_A || key_r == K_FN_B) begin
            fn_nxt = press_r;
          end else if (key_r == K_CAPS) begin
            if (press_r) caps_nxt = !caps_r;
          end else if (is_arrow) begin
            // handled by the arrow slots
          end else if (key_r == K_ENTER_A || key_r == K_ENTER_B) begin
            sel = press_r;
          end else if (key_r == K_ESC_A || key_r == K_ESC_B) begin
            esc = press_r;
          end else if (key_r == K_DEL) begin
            esc = press_r;
            del = press_r;
          end else if (press_r && raw_char != '0) begin
            cvalid = 1'b1;
            ccode  = raw_char;
            if (raw_char >= CH_LOWER_A && raw_char <= CH_LOWER_Z) begin
              if (shift_r != caps_r) ccode = raw_char - CASE_DELTA;
            end else if (shift_r && raw_char >= CH_DIGIT_0 && raw_char <= CH_DIGIT_9) begin
              ccode = digit_sym(raw_char[3:0]);
            end
          end else begin
            // release of a plain key or a key without a character: nothing typed
          end
        end
      end
      default: begin
        // tick and overflow leave the modifiers alone
      end
    endcase
  end

  // One tracker per arrow slot
  for (genvar i = 0; i < NUM_ARROWS; i++) begin : g_arrow
    always_comb begin
      arrow_ctl[i].en    = adv;
      arrow_ctl[i].tick  = (cmd_r == CMD_TICK);
      arrow_ctl[i].clear = (cmd_r == CMD_OVERFLOW) || (cmd_r == CMD_RECONNECT);
      arrow_ctl[i].press = (cmd_r == CMD_KEY) && (key_r == ARROW_KEY[i]) && press_r;
      arrow_ctl[i].lift  = (cmd_r == CMD_KEY) && (key_r == ARROW_KEY[i]) && !press_r;
    end

    ked_arrow u_arrow (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (arrow_ctl[i]),
      .cfg   (cfg_r),
      .pulse (arrow_pulse[i])
    );
  end

  // Assemble the result transaction
  always_comb begin
    res_nxt.char_valid   = cvalid;
    res_nxt.char_code    = ccode;
    res_nxt.arrow_pulse  = arrow_pulse;
    res_nxt.select_pulse = sel;
    res_nxt.escape_pulse = esc;
    res_nxt.delete_pulse = del;
    res_nxt.fn_held      = fn_nxt;
    res_nxt.ctrl_held    = ctrl_nxt;
    res_nxt.alt_held     = alt_nxt;
  end

  // Control state, modifiers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      shift_r      <= 1'b0;
      caps_r       <= 1'b0;
      fn_r         <= 1'b0;
      ctrl_r       <= 1'b0;
      alt_r        <= 1'b0;
      cfg_r.start    <= RST_REPEAT_START;
      cfg_r.period   <= RST_REPEAT_PERIOD;
      cfg_r.hold_max <= RST_HOLD_MAX;
    end else begin
      in_vld_r    <= in_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        shift_r <= shift_nxt;
        caps_r  <= caps_nxt;
        fn_r    <= fn_nxt;
        ctrl_r  <= ctrl_nxt;
        alt_r   <= alt_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_REPEAT_START:  cfg_r.start    <= cfg_data;
          CFG_REPEAT_PERIOD: cfg_r.period   <= cfg_data;
          CFG_HOLD_MAX:      cfg_r.hold_max <= cfg_data;
          default: begin
            // unused index: drop the write
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r   <= cmd_t'(in_cmd);
      key_r   <= in_key_number;
      press_r <= in_key_pressed;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char_valid   = res_r.char_valid;
  assign out_char_code    = res_r.char_code;
  assign out_next_pulse   = res_r.arrow_pulse[0];
  assign out_prev_pulse   = res_r.arrow_pulse[1];
  assign out_up_pulse     = res_r.arrow_pulse[2];
  assign out_down_pulse   = res_r.arrow_pulse[3];
  assign out_select_pulse = res_r.select_pulse;
  assign out_escape_pulse = res_r.escape_pulse;
  assign out_delete_pulse = res_r.delete_pulse;
  assign out_fn_held      = res_r.fn_held;
  assign out_ctrl_held    = res_r.ctrl_held;
  assign out_alt_held     = res_r.alt_held;

endmodule

`default_nettype wire

[rtl/core/ked_checker.sv]
// Port-level assertions for key_event_decoder_autorepeat, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module ked_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_char_valid,
  input wire logic [6:0] out_char_code,
  input wire logic       out_next_pulse,
  input wire logic       out_prev_pulse,
  input wire logic       out_up_pulse,
  input wire logic       out_down_pulse,
  input wire logic       out_select_pulse,
  input wire logic       out_escape_pulse,
  input wire logic       out_delete_pulse,
  input wire logic       out_fn_held,
  input wire logic       out_ctrl_held,
  input wire logic       out_alt_held
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_char_valid, out_char_code, out_next_pulse, out_prev_pulse,
               out_up_pulse, out_down_pulse, out_select_pulse, out_escape_pulse,
               out_delete_pulse, out_fn_held, out_ctrl_held, out_alt_held}))
    else $error("stalled result changed");

  // No code without a typed character
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_char_code == 7'd0)
    else $error("char code without char valid");

  // Delete always reports as escape too
  a_del_esc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_delete_pulse |-> out_escape_pulse)
    else $error("delete without escape");

  // One key event types a character or flags one special key, never two
  a_one_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_char_valid, out_select_pulse, out_escape_pulse}) <= 1)
    else $error("more than one key action in a result");

endmodule

bind key_event_decoder_autorepeat ked_checker u_ked_checker (.*);

`default_nettype wire

[dv/key_event_decoder_autorepeat_tb.sv]
// Self-checking testbench for key_event_decoder_autorepeat: a clocked driver, receiver
// and monitor, plus a keyboard-state predictor that forecasts each result transaction.
// Depends on ked_pkg for the port types, command codes, key numbers and register indexes.
`timescale 1ns / 100ps

module key_event_decoder_autorepeat_tb;
  import ked_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD_CYCLES = 300;

  // Printable character per key number minus one; zero means no character
  localparam ascii_t CHAR_OF_KEY [NUM_KEYS] = '{
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70,
    7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C,
    7'h00, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h20, 7'h20, 7'h20, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h39, 7'h00, 7'h00, 7'h00, 7'h00, 7'h30, 7'h00
  };

  // Symbol typed by a shifted digit, indexed by the digit value
  localparam ascii_t SHIFTED_DIGIT [10] = '{
    7'h29, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28
  };

  localparam key_t MODIFIER_KEY [6] = '{K_SHIFT, K_CTRL, K_ALT, K_FN_A, K_FN_B, K_CAPS};

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_style_e;

  typedef struct packed {
    cmd_t cmd;
    key_t key;
    logic pressed;
  } key_item_t;

  typedef struct packed {
    logic                  char_valid;
    ascii_t                char_code;
    logic [NUM_ARROWS-1:0] arrow_pulse;   // right, left, up, down
    logic                  sel;
    logic                  esc;
    logic                  del;
    logic                  fn;
    logic                  ctrl;
    logic                  alt;
  } key_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [6:0]  in_key_number = '0;
  logic        in_key_pressed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_char_valid;
  logic [6:0]  out_char_code;
  logic        out_next_pulse;
  logic        out_prev_pulse;
  logic        out_up_pulse;
  logic        out_down_pulse;
  logic        out_select_pulse;
  logic        out_escape_pulse;
  logic        out_delete_pulse;
  logic        out_fn_held;
  logic        out_ctrl_held;
  logic        out_alt_held;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  key_event_decoder_autorepeat DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_key_number    (in_key_number),
    .in_key_pressed   (in_key_pressed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_valid   (out_char_valid),
    .out_char_code    (out_char_code),
    .out_next_pulse   (out_next_pulse),
    .out_prev_pulse   (out_prev_pulse),
    .out_up_pulse     (out_up_pulse),
    .out_down_pulse   (out_down_pulse),
    .out_select_pulse (out_select_pulse),
    .out_escape_pulse (out_escape_pulse),
    .out_delete_pulse (out_delete_pulse),
    .out_fn_held      (out_fn_held),
    .out_ctrl_held    (out_ctrl_held),
    .out_alt_held     (out_alt_held),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  // Pending input transactions and forecast results
  key_item_t   key_item_q[$];
  key_result_t decoded_q[$];
  int          items_pushed = 0;
  int          results_seen = 0;
  int          cfg_acks = 0;
  int          mismatches = 0;
  logic        in_fire = 1'b0;

  // Traffic shaping, set between phases
  bit           sender_gaps = 1'b0;
  stall_style_e stall_style = STALL_NONE;
  bit           long_hold_req = 1'b0;

  // Predictor state: keyboard modifiers, held arrows and timing registers
  logic     shift_on = 1'b0, caps_on = 1'b0, fn_on = 1'b0, ctrl_on = 1'b0, alt_on = 1'b0;
  logic     arrow_down [NUM_ARROWS] = '{default: 1'b0};
  time_t    hold_ms    [NUM_ARROWS] = '{default: '0};
  time_t    repeat_at  [NUM_ARROWS] = '{default: '0};
  cfg_val_t start_ms  = RST_REPEAT_START;
  cfg_val_t period_ms = RST_REPEAT_PERIOD;
  cfg_val_t drop_ms   = RST_HOLD_MAX;

  // Clamp a widened time sum to the largest representable age
  function automatic time_t clamp_ms(input logic [TIME_WIDTH+1:0] v);
    if (v > (TIME_WIDTH + 2)'(TIME_MAX)) return TIME_MAX;
    return v[TIME_WIDTH-1:0];
  endfunction

  // Advance the keyboard state by one transaction and forecast its result
  function automatic key_result_t decode_item(input cmd_t cmd, input key_t key,
                                              input logic pressed);
    key_result_t r;
    int          slot;
    int          i;
    ascii_t      c;
    r = '0;
    slot = -1;
    case (cmd)
      CMD_TICK: begin
        for (i = 0; i < NUM_ARROWS; i++)
          if (arrow_down[i])
            hold_ms[i] = clamp_ms({2'b00, hold_ms[i]} + (TIME_WIDTH + 2)'(1));
      end
      CMD_OVERFLOW: begin
        for (i = 0; i < NUM_ARROWS; i++) arrow_down[i] = 1'b0;
      end
      CMD_RECONNECT: begin
        for (i = 0; i < NUM_ARROWS; i++) arrow_down[i] = 1'b0;
        shift_on = 1'b0;
        caps_on = 1'b0;
        fn_on = 1'b0;
        ctrl_on = 1'b0;
        alt_on = 1'b0;
      end
      default: begin
        // Key numbers outside the matrix change nothing
        if (key >= 1 && key <= NUM_KEYS) begin
          for (i = 0; i < NUM_ARROWS; i++)
            if (key == ARROW_KEY[i]) slot = i;
          if (key == K_SHIFT) shift_on = pressed;
          else if (key == K_CTRL) ctrl_on = pressed;
          else if (key == K_ALT) alt_on = pressed;
          else if (key == K_FN_A || key == K_FN_B) fn_on = pressed;
          else if (key == K_CAPS) begin
            if (pressed) caps_on = !caps_on;
          end else if (slot >= 0) begin
            arrow_down[slot] = pressed;
            if (pressed) begin
              r.arrow_pulse[slot] = 1'b1;
              hold_ms[slot] = '0;
              repeat_at[slot] = clamp_ms({2'b00, start_ms});
            end
          end else if (key == K_ENTER_A || key == K_ENTER_B) begin
            r.sel = pressed;
          end else if (key == K_ESC_A || key == K_ESC_B) begin
            r.esc = pressed;
          end else if (key == K_DEL) begin
            r.esc = pressed;
            r.del = pressed;
          end else if (pressed) begin
            c = CHAR_OF_KEY[key - 1];
            if (c != '0) begin
              if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
                if (shift_on != caps_on) c = c - CASE_DELTA;
              end else if (shift_on && c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
                c = SHIFTED_DIGIT[c - CH_DIGIT_0];
              end
              r.char_valid = 1'b1;
              r.char_code = c;
            end
          end
        end
      end
    endcase
    // Drop arrows held too long, then fire due repeats
    for (i = 0; i < NUM_ARROWS; i++)
      if (arrow_down[i] && hold_ms[i] > drop_ms) arrow_down[i] = 1'b0;
    for (i = 0; i < NUM_ARROWS; i++) begin
      if (arrow_down[i] && hold_ms[i] >= repeat_at[i]) begin
        r.arrow_pulse[i] = 1'b1;
        repeat_at[i] = clamp_ms({2'b00, hold_ms[i]} + {2'b00, period_ms});
      end
    end
    r.fn = fn_on;
    r.ctrl = ctrl_on;
    r.alt = alt_on;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Watch all three channels: forecast accepted items, apply register writes, check results
  always @(posedge clk) begin : monitor
    key_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        decoded_q.insert(decoded_q.size(),
                         decode_item(cmd_t'(in_cmd), in_key_number, in_key_pressed));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REPEAT_START:  start_ms = cfg_data;
          CFG_REPEAT_PERIOD: period_ms = cfg_data;
          CFG_HOLD_MAX:      drop_ms = cfg_data;
          default: ;
        endcase
        cfg_acks <= cfg_acks + 1;
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("result transaction with no forecast waiting");
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("char_valid", want.char_valid, out_char_valid);
          check_field("char_code", want.char_code, out_char_code);
          check_field("next_pulse", want.arrow_pulse[0], out_next_pulse);
          check_field("prev_pulse", want.arrow_pulse[1], out_prev_pulse);
          check_field("up_pulse", want.arrow_pulse[2], out_up_pulse);
          check_field("down_pulse", want.arrow_pulse[3], out_down_pulse);
          check_field("select_pulse", want.sel, out_select_pulse);
          check_field("escape_pulse", want.esc, out_escape_pulse);
          check_field("delete_pulse", want.del, out_delete_pulse);
          check_field("fn_held", want.fn, out_fn_held);
          check_field("ctrl_held", want.ctrl, out_ctrl_held);
          check_field("alt_held", want.alt, out_alt_held);
          results_seen <= results_seen + 1;
        end
      end
    end
    in_fire <= rst_n && in_valid && !in_stall;
  end

  // Offer queued transactions in bursts, holding the payload while stalled
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : driver
    key_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (key_item_q.size() > 0) begin
        it = key_item_q.pop_front();
        in_valid <= 1'b1;
        in_cmd <= it.cmd;
        in_key_number <= it.key;
        in_key_pressed <= it.pressed;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          gap_left <= sender_gaps ? $urandom_range(1, 8) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, with one long hold-off on request
  int   hold_off_left = 0;
  bit   hold_off_done = 1'b0;
  int   stall_run = 0;
  logic stall_level = 1'b0;

  always @(negedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else if (long_hold_req && !hold_off_done) begin
      out_stall <= 1'b1;
      hold_off_left <= LONG_HOLD_CYCLES;
      hold_off_done <= 1'b1;
    end else begin
      case (stall_style)
        STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_RUNS: begin
          if (stall_run == 0) begin
            stall_level <= !stall_level;
            stall_run <= $urandom_range(1, 8);
            out_stall <= !stall_level;
          end else begin
            stall_run <= stall_run - 1;
            out_stall <= stall_level;
          end
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // End the run when nothing has been accepted on any channel for too long
  int idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall)
        && !(cfg_valid && cfg_ready)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  task automatic push_item(input cmd_t cmd, input key_t key, input logic pressed);
    key_item_q.insert(key_item_q.size(), '{cmd, key, pressed});
    items_pushed++;
  endtask

  task automatic push_key(input key_t key, input logic pressed);
    push_item(CMD_KEY, key, pressed);
  endtask

  // Non-key commands carry random key fields, which the block must ignore
  task automatic push_cmd(input cmd_t cmd);
    push_item(cmd, key_t'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_cmd(CMD_TICK);
  endtask

  task automatic write_reg(input logic [1:0] idx, input cfg_val_t val);
    int seen;
    seen = cfg_acks;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    while (cfg_acks == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input cfg_val_t start, input cfg_val_t period,
                            input cfg_val_t hold);
    write_reg(CFG_REPEAT_START, start);
    write_reg(CFG_REPEAT_PERIOD, period);
    write_reg(CFG_HOLD_MAX, hold);
  endtask

  // Hold until every forecast result has been checked
  task automatic drain();
    while (results_seen != items_pushed) @(negedge clk);
  endtask

  // Mostly arrow holds and typed sequences with random content, plus noise
  task automatic random_traffic(input int n, input int tick_max);
    int   base;
    int   roll;
    key_t arrow;
    key_t modifier;
    base = items_pushed;
    while (items_pushed - base < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        arrow = ARROW_KEY[$urandom_range(0, NUM_ARROWS - 1)];
        push_key(arrow, 1'b1);
        repeat ($urandom_range(1, tick_max)) begin
          case ($urandom_range(0, 19))
            0, 1, 2: push_key(key_t'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            3, 4:    push_key(ARROW_KEY[$urandom_range(0, NUM_ARROWS - 1)],
                              1'($urandom_range(0, 1)));
            5:       push_cmd($urandom_range(0, 1) ? CMD_OVERFLOW : CMD_RECONNECT);
            default: push_cmd(CMD_TICK);
          endcase
        end
        if ($urandom_range(0, 3) != 0) push_key(arrow, 1'b0);
      end else if (roll < 65) begin
        push_key(key_t'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else if (roll < 78) begin
        modifier = MODIFIER_KEY[$urandom_range(0, 5)];
        push_key(modifier, 1'b1);
        repeat ($urandom_range(1, 4)) push_key(key_t'($urandom_range(11, 68)), 1'b1);
        if ($urandom_range(0, 9) < 7) push_key(modifier, 1'b0);
      end else if (roll < 93) begin
        push_ticks($urandom_range(1, 4));
      end else if (roll < 97) begin
        push_cmd(CMD_OVERFLOW);
      end else begin
        push_cmd(CMD_RECONNECT);
      end
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: characters, shift and caps, flag keys, modifiers, ignored numbers
    push_key(7'd32, 1'b1);
    push_key(K_SHIFT, 1'b1);
    push_key(7'd32, 1'b1);
    push_key(7'd13, 1'b1);
    push_key(7'd67, 1'b1);
    push_key(7'd62, 1'b1);
    push_key(7'd55, 1'b1);
    push_key(K_CAPS, 1'b1);
    push_key(7'd21, 1'b1);
    push_key(K_SHIFT, 1'b0);
    push_key(K_CAPS, 1'b0);
    push_key(7'd48, 1'b1);
    push_key(7'd14, 1'b0);
    push_key(K_ENTER_A, 1'b1);
    push_key(K_ENTER_B, 1'b1);
    push_key(K_ESC_A, 1'b1);
    push_key(K_ESC_B, 1'b1);
    push_key(K_DEL, 1'b1);
    push_key(K_CTRL, 1'b1);
    push_key(K_ALT, 1'b1);
    push_key(K_FN_A, 1'b1);
    push_key(7'd0, 1'b1);
    push_key(7'd127, 1'b1);
    push_key(7'd69, 1'b1);
    push_key(K_RIGHT, 1'b1);
    push_cmd(CMD_OVERFLOW);
    push_cmd(CMD_RECONNECT);
    // Default repeat timing on a held left arrow
    push_key(K_LEFT, 1'b1);
    push_ticks(505);
    push_key(K_LEFT, 1'b0);
    drain();

    // Short timing, bursty sender, random stalls
    sender_gaps = 1'b1;
    stall_style = STALL_RANDOM;
    set_timing(13'd3, 13'd2, 13'd20);
    random_traffic(150, 30);
    drain();

    // All registers zero: repeat on every item, drop on first tick
    stall_style = STALL_RUNS;
    set_timing('0, '0, '0);
    random_traffic(100, 6);
    drain();

    // Full-rate sender against one long receiver hold-off
    sender_gaps = 1'b0;
    stall_style = STALL_NONE;
    set_timing(13'd1, 13'd1, 13'd8000);
    long_hold_req = 1'b1;
    random_traffic(120, 40);
    drain();

    // Largest register values: repeat times saturate at once
    stall_style = STALL_RANDOM;
    set_timing(TIME_MAX, TIME_MAX, TIME_MAX);
    push_key(K_RIGHT, 1'b1);
    push_ticks(40);
    push_key(K_UP, 1'b1);
    push_ticks(3);
    push_key(K_RIGHT, 1'b0);
    push_ticks(2);
    push_cmd(CMD_OVERFLOW);
    drain();

    // Random small timings with random traffic shaping
    repeat (3) begin
      sender_gaps = 1'($urandom_range(0, 1));
      stall_style = stall_style_e'($urandom_range(0, 2));
      set_timing(cfg_val_t'($urandom_range(0, 12)), cfg_val_t'($urandom_range(0, 6)),
                 cfg_val_t'($urandom_range(0, 60)));
      random_traffic(80, 70);
      drain();
    end

    // Wide-range registers
    sender_gaps = 1'b1;
    stall_style = STALL_RUNS;
    set_timing(cfg_val_t'($urandom_range(0, 8191)), cfg_val_t'($urandom_range(0, 15)),
               cfg_val_t'($urandom_range(0, 8191)));
    random_traffic(50, 60);
    drain();

    // Let any stray result surface before the verdict
    repeat (8) @(negedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
